[rtl/pbs_pkg.sv]
// ----------------------------------------------------------------------------
// pbs_pkg
// shared types and widths of the priority batch scheduler
// ----------------------------------------------------------------------------
package pbs_pkg;

	localparam int BURST_W = 16;
	localparam int PRIO_W  = 8;
	localparam int ID_W    = 5;
	localparam int TIME_W  = 20;

	// one stored job of the sorted table
	typedef struct packed {
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
		logic [ID_W-1:0]    id;
	} entry_t;

	// one job on its way from the front to the back
	typedef struct packed {
		entry_t ent;
		logic   ovf;
		logic   last;
	} job_t;

	// push beat from the front into the back queue
	typedef struct packed {
		logic valid;
		job_t job;
	} push_t;

	// status the back reports to the front
	typedef struct packed {
		logic full;
	} back_stat_t;

	// front states, one-hot
	typedef enum logic [1:0] {
		ST_LOAD  = 2'b01,
		ST_DRAIN = 2'b10
	} front_state_t;

endpackage

[rtl/priority_batch_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// priority_batch_scheduler_unit
// non-preemptive priority scheduler for one batch of jobs at a time
// ----------------------------------------------------------------------------
// usage
//  - input beat: burst_time, job_priority and last_job are taken at a rising
//    edge where start is high and busy is low; one job per cycle while loading
//  - each job is placed into a priority-sorted table as it arrives, equal
//    priorities keeping load order; jobs beyond MAX_JOBS are dropped and the
//    whole batch reports overflow
//  - a beat with last_job closes the batch: busy rises and the table drains
//    head first into the short emitter queue, one job per cycle unless full
//  - result beats: result_valid strobes for one cycle per job, in ascending
//    priority, with running wait_time and turnaround (saturating at 20 bits);
//    last_out marks the final job of the batch
//  - order: the closing beat moves the front into drain, the head job passes
//    the queue and the result register, then one result per cycle follows
//    while draining; busy stays high until the last job has left the table
//  - loading waits for the drain, set by the single read-out port of the table
//  - the receiver cannot stall: every result beat is taken as it appears
//  - reset empties the table, the queue and the running sums
// ----------------------------------------------------------------------------
module priority_batch_scheduler_unit #(
	parameter int MAX_JOBS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input beat
	input  logic                          start,
	output logic                          busy,
	input  logic [pbs_pkg::BURST_W-1:0]   burst_time,
	input  logic [pbs_pkg::PRIO_W-1:0]    job_priority,
	input  logic                          last_job,
	// result beat
	output logic                          result_valid,
	output logic [pbs_pkg::ID_W-1:0]      job_id,
	output logic [pbs_pkg::BURST_W-1:0]   out_burst,
	output logic [pbs_pkg::PRIO_W-1:0]    out_priority,
	output logic [pbs_pkg::TIME_W-1:0]    wait_time,
	output logic [pbs_pkg::TIME_W-1:0]    turnaround,
	output logic                          overflow,
	output logic                          last_out
);

	// push beats from the sorted table and queue status back to it
	pbs_pkg::push_t      push;
	pbs_pkg::back_stat_t stat;

	// front: sorted insertion while loading, in-order drain after the batch closes
	pbs_front #(
		.MAX_JOBS (MAX_JOBS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.burst_time   (burst_time),
		.job_priority (job_priority),
		.last_job     (last_job),
		.busy         (busy),
		.stat         (stat),
		.push         (push)
	);

	// back: queue, running sums and registered result beat
	pbs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.stat         (stat),
		.result_valid (result_valid),
		.job_id       (job_id),
		.out_burst    (out_burst),
		.out_priority (out_priority),
		.wait_time    (wait_time),
		.turnaround   (turnaround),
		.overflow     (overflow),
		.last_out     (last_out)
	);

endmodule

[rtl/pbs_front.sv]
// ----------------------------------------------------------------------------
// pbs_front
// loads jobs into a priority-sorted table and drains it in order
// ----------------------------------------------------------------------------
module pbs_front #(
	parameter int MAX_JOBS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pbs_pkg::BURST_W-1:0]   burst_time,
	input  logic [pbs_pkg::PRIO_W-1:0]    job_priority,
	input  logic                          last_job,
	output logic                          busy,
	input  pbs_pkg::back_stat_t           stat,
	output pbs_pkg::push_t                push
);

	localparam int CNT_W = $clog2(MAX_JOBS + 1);

	pbs_pkg::front_state_t state_q;
	pbs_pkg::entry_t       ent_q [MAX_JOBS];
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      remain_q;
	logic                  ovf_q;
	logic                  batch_ovf_q;

	logic                  accept;
	logic                  full_tab;
	logic                  store;
	logic                  drain;
	logic [MAX_JOBS-1:0]   gt;
	logic [MAX_JOBS-1:0]   ins;
	pbs_pkg::entry_t       new_ent;

	assign busy     = (state_q == pbs_pkg::ST_DRAIN);
	assign accept   = start && !busy;
	assign full_tab = (count_q == CNT_W'(MAX_JOBS));
	assign store    = accept && !full_tab;
	assign drain    = (state_q == pbs_pkg::ST_DRAIN) && !stat.full;

	assign new_ent.burst = burst_time;
	assign new_ent.prio  = job_priority;
	assign new_ent.id    = pbs_pkg::ID_W'(32'(count_q) + 32'd1);

	// stored entries that the new job must pass; the table is sorted so gt is monotone
	always_comb begin
		for (int k = 0; k < MAX_JOBS; k++) begin
			gt[k] = (CNT_W'(k) < count_q) && (ent_q[k].prio > job_priority);
		end
		for (int k = 0; k < MAX_JOBS; k++) begin
			ins[k] = (gt[k] || (CNT_W'(k) == count_q)) && !((k > 0) && gt[(k > 0) ? k - 1 : 0]);
		end
	end

	for (genvar k = 0; k < MAX_JOBS; k++) begin : g_ent
		always_ff @(posedge clk) begin
			if (drain) begin
				if (k < MAX_JOBS - 1) begin
					ent_q[k] <= ent_q[(k < MAX_JOBS - 1) ? k + 1 : k];
				end
			end else if (store) begin
				if ((k > 0) && gt[(k > 0) ? k - 1 : 0]) begin
					ent_q[k] <= ent_q[(k > 0) ? k - 1 : 0];
				end else if (ins[k]) begin
					ent_q[k] <= new_ent;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pbs_pkg::ST_LOAD;
			count_q     <= '0;
			remain_q    <= '0;
			ovf_q       <= 1'b0;
			batch_ovf_q <= 1'b0;
		end else begin
			unique case (state_q)
				pbs_pkg::ST_LOAD: begin
					if (accept) begin
						if (last_job) begin
							state_q     <= pbs_pkg::ST_DRAIN;
							remain_q    <= count_q + CNT_W'(store);
							batch_ovf_q <= ovf_q || full_tab;
							count_q     <= '0;
							ovf_q       <= 1'b0;
						end else if (full_tab) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				pbs_pkg::ST_DRAIN: begin
					if (drain) begin
						remain_q <= remain_q - 1'b1;
						if (remain_q == CNT_W'(1)) begin
							state_q <= pbs_pkg::ST_LOAD;
						end
					end
				end
				default: state_q <= pbs_pkg::ST_LOAD;
			endcase
		end
	end

	assign push.valid    = drain;
	assign push.job.ent  = ent_q[0];
	assign push.job.ovf  = batch_ovf_q;
	assign push.job.last = (remain_q == CNT_W'(1));

endmodule

[rtl/pbs_back.sv]
// ----------------------------------------------------------------------------
// pbs_back
// job queue and emitter with running wait and turnaround sums
// ----------------------------------------------------------------------------
module pbs_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pbs_pkg::push_t                push,
	output pbs_pkg::back_stat_t           stat,
	output logic                          result_valid,
	output logic [pbs_pkg::ID_W-1:0]      job_id,
	output logic [pbs_pkg::BURST_W-1:0]   out_burst,
	output logic [pbs_pkg::PRIO_W-1:0]    out_priority,
	output logic [pbs_pkg::TIME_W-1:0]    wait_time,
	output logic [pbs_pkg::TIME_W-1:0]    turnaround,
	output logic                          overflow,
	output logic                          last_out
);

	localparam int Q_DEPTH = 4;
	localparam int QP_W    = $clog2(Q_DEPTH);
	localparam int QC_W    = $clog2(Q_DEPTH + 1);
	localparam logic [pbs_pkg::TIME_W:0] TIME_MAX = {1'b0, {pbs_pkg::TIME_W{1'b1}}};

	pbs_pkg::job_t              q_mem [Q_DEPTH];
	logic [QP_W-1:0]            wr_ptr_q;
	logic [QP_W-1:0]            rd_ptr_q;
	logic [QC_W-1:0]            q_cnt_q;
	logic [pbs_pkg::TIME_W-1:0] wait_acc_q;
	logic                       valid_q;
	pbs_pkg::job_t              job_q;
	logic [pbs_pkg::TIME_W-1:0] wait_q;
	logic [pbs_pkg::TIME_W-1:0] turn_q;

	logic                       pop;
	pbs_pkg::job_t              head;
	logic [pbs_pkg::TIME_W:0]   sum;
	logic [pbs_pkg::TIME_W-1:0] sat_sum;

	assign stat.full = (q_cnt_q == QC_W'(Q_DEPTH));
	assign pop       = (q_cnt_q != '0);
	assign head      = q_mem[rd_ptr_q];

	// saturating running sum
	assign sum     = {1'b0, wait_acc_q} + (pbs_pkg::TIME_W + 1)'(head.ent.burst);
	assign sat_sum = (sum > TIME_MAX) ? TIME_MAX[pbs_pkg::TIME_W-1:0] : sum[pbs_pkg::TIME_W-1:0];

	always_ff @(posedge clk) begin
		if (push.valid && !stat.full) begin
			q_mem[wr_ptr_q] <= push.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			q_cnt_q    <= '0;
			wait_acc_q <= '0;
			valid_q    <= 1'b0;
		end else begin
			if (push.valid && !stat.full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q   <= rd_ptr_q + 1'b1;
				wait_acc_q <= head.last ? '0 : sat_sum;
			end
			q_cnt_q <= q_cnt_q + QC_W'(push.valid && !stat.full) - QC_W'(pop);
			valid_q <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q  <= head;
			wait_q <= wait_acc_q;
			turn_q <= sat_sum;
		end
	end

	assign result_valid = valid_q;
	assign job_id       = job_q.ent.id;
	assign out_burst    = job_q.ent.burst;
	assign out_priority = job_q.ent.prio;
	assign wait_time    = wait_q;
	assign turnaround   = turn_q;
	assign overflow     = job_q.ovf;
	assign last_out     = job_q.last;

endmodule

[test/priority_batch_scheduler_unit_tb.sv]
// ----------------------------------------------------------------------------
// priority_batch_scheduler_unit_tb
// self-checking bench for the priority batch scheduler: job beats go in on
// the start/busy handshake, each scheduled job coming out is checked field by
// field against a behavioural copy of the sorted table and running sums
// ----------------------------------------------------------------------------
module priority_batch_scheduler_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          BURST_W    = pbs_pkg::BURST_W;
	localparam int          PRIO_W     = pbs_pkg::PRIO_W;
	localparam int          ID_W       = pbs_pkg::ID_W;
	localparam int          TIME_W     = pbs_pkg::TIME_W;

	localparam int          MAX_JOBS   = 16;
	localparam int unsigned TIME_MAX   = (1 << TIME_W) - 1;
	localparam int unsigned STALL_MAX  = 2000;
	localparam int unsigned RAND_JOBS  = 346;

	// one scheduled job as it leaves the block
	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
		logic [TIME_W-1:0]  wait_cyc;
		logic [TIME_W-1:0]  turn_cyc;
		logic               ovf;
		logic               closes;
	} sched_t;

	// one job beat, with its result typed in where it is obvious
	typedef struct packed {
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
		logic               is_last;
		logic               has_res;
		sched_t             res;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [BURST_W-1:0] burst_time = '0;
	logic [PRIO_W-1:0]  job_priority = '0;
	logic               last_job = 1'b0;
	logic               result_valid;
	logic [ID_W-1:0]    job_id;
	logic [BURST_W-1:0] out_burst;
	logic [PRIO_W-1:0]  out_priority;
	logic [TIME_W-1:0]  wait_time;
	logic [TIME_W-1:0]  turnaround;
	logic               overflow;
	logic               last_out;

	// typed-in result travelling alongside the beat it belongs to
	logic               row_typed = 1'b0;
	sched_t             row_res = '0;

	// own copy of the job table
	logic [BURST_W-1:0] tbl_burst [MAX_JOBS];
	logic [PRIO_W-1:0]  tbl_prio [MAX_JOBS];
	int unsigned        tbl_count = 0;
	logic               tbl_ovf = 1'b0;

	// scheduled jobs still to come out, oldest first
	sched_t             sched_q[$];
	int unsigned        mismatch_count = 0;
	int unsigned        stall_cycles = 0;

	priority_batch_scheduler_unit #(
		.MAX_JOBS(MAX_JOBS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.burst_time(burst_time),
		.job_priority(job_priority),
		.last_job(last_job),
		.result_valid(result_valid),
		.job_id(job_id),
		.out_burst(out_burst),
		.out_priority(out_priority),
		.wait_time(wait_time),
		.turnaround(turnaround),
		.overflow(overflow),
		.last_out(last_out)
	);

	// 10 ns clock, low half first
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// store one accepted job beat; a closing beat sorts the batch and queues
	// every job it will schedule, with its wait and turnaround, or the typed-in result
	task automatic admit_job(input logic [BURST_W-1:0] b, input logic [PRIO_W-1:0] p,
			input logic closing, input logic typed, input sched_t typed_res);
		int          order [MAX_JOBS];
		int          n;
		int          j;
		int unsigned run;
		int unsigned sum;
		sched_t      r;
		run = 0;
		// a full table drops the job, even the closing one
		if (tbl_count < MAX_JOBS) begin
			tbl_burst[tbl_count] = b;
			tbl_prio[tbl_count] = p;
			tbl_count++;
		end else begin
			tbl_ovf = 1'b1;
		end
		if (!closing)
			return;
		n = tbl_count;
		// insertion sort on priority, ties stay in load order
		for (int i = 0; i < n; i++) begin
			j = i;
			while (j > 0 && tbl_prio[order[j-1]] > tbl_prio[i]) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = i;
		end
		if (typed) begin
			sched_q.push_back(typed_res);
		end else begin
			for (int i = 0; i < n; i++) begin
				r.id       = ID_W'(order[i] + 1);
				r.burst    = tbl_burst[order[i]];
				r.prio     = tbl_prio[order[i]];
				r.wait_cyc = TIME_W'(run);
				sum        = run + tbl_burst[order[i]];
				if (sum > TIME_MAX)
					sum = TIME_MAX;
				r.turn_cyc = TIME_W'(sum);
				r.ovf      = tbl_ovf;
				r.closes   = (i + 1 == n);
				sched_q.push_back(r);
				run = sum;
			end
		end
		tbl_count = 0;
		tbl_ovf = 1'b0;
	endtask

	// one job beat: optional idle cycles, then hold start until busy is low.
	// start is left high on return so back-to-back beats never toggle it
	task automatic drive_job(input stim_row_t row, input int unsigned idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start        <= 1'b1;
		burst_time   <= row.burst;
		job_priority <= row.prio;
		last_job     <= row.is_last;
		row_typed    <= row.has_res;
		row_res      <= row.res;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// result checker and beat monitor, sampling pre-edge values
	always @(posedge clk) begin
		sched_t want;
		if (arst_n) begin
			if (result_valid) begin
				if (sched_q.size() == 0) begin
					$error("job %0d scheduled with nothing outstanding", job_id);
					mismatch_count++;
				end else begin
					want = sched_q.pop_front();
					check_field("job_id", want.id, job_id);
					check_field("out_burst", want.burst, out_burst);
					check_field("out_priority", want.prio, out_priority);
					check_field("wait_time", want.wait_cyc, wait_time);
					check_field("turnaround", want.turn_cyc, turnaround);
					check_field("overflow", want.ovf, overflow);
					check_field("last_out", want.closes, last_out);
				end
			end
			if (start && !busy)
				admit_job(burst_time, job_priority, last_job, row_typed, row_res);
		end
	end

	// watchdog: cycles with neither an input beat nor a result beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_MAX) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t   directed_rows[$];
		stim_row_t   row;
		int unsigned sent;
		int unsigned batch_len;
		int unsigned idle_pct;
		int unsigned sel;
		bit          narrow;

		// single-job batches at the extremes: the job comes straight back
		directed_rows.push_back('{16'hFFFF, 8'hFF, 1'b1, 1'b1,
			'{5'd1, 16'hFFFF, 8'hFF, 20'd0, 20'd65535, 1'b0, 1'b1}});
		directed_rows.push_back('{16'h0000, 8'h00, 1'b1, 1'b1,
			'{5'd1, 16'h0000, 8'h00, 20'd0, 20'd0, 1'b0, 1'b1}});
		// mixed priorities with ties, lowest priority loaded late
		directed_rows.push_back('{16'd100, 8'd5, 1'b0, 1'b0, '0});
		directed_rows.push_back('{16'd200, 8'd3, 1'b0, 1'b0, '0});
		directed_rows.push_back('{16'd300, 8'd5, 1'b0, 1'b0, '0});
		directed_rows.push_back('{16'd400, 8'd0, 1'b0, 1'b0, '0});
		directed_rows.push_back('{16'd50, 8'd3, 1'b1, 1'b0, '0});
		// full table plus one: the closing job itself is dropped, overflow set
		for (int k = 0; k <= MAX_JOBS; k++)
			directed_rows.push_back('{BURST_W'(k * 4000 + 1), PRIO_W'((MAX_JOBS - k) % 5),
				k == MAX_JOBS, 1'b0, '0});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			drive_job(directed_rows[i], 14);

		// random batches; sender idling 14 %, then 70 %, then none at all
		sent = 0;
		while (sent < RAND_JOBS) begin
			sel = $urandom_range(99);
			if (sel < 10)
				batch_len = $urandom_range(MAX_JOBS + 4, MAX_JOBS + 1);
			else if (sel < 25)
				batch_len = MAX_JOBS;
			else
				batch_len = $urandom_range(12, 1);
			// narrow priorities give plenty of ties
			narrow = 1'($urandom_range(1));
			for (int k = 0; k < batch_len; k++) begin
				idle_pct = (sent < RAND_JOBS / 3) ? 14 :
					(sent < 2 * RAND_JOBS / 3) ? 70 : 0;
				sel = $urandom_range(7);
				row.burst   = (sel == 0) ? '0 : (sel == 1) ? '1 : BURST_W'($urandom);
				row.prio    = narrow ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom);
				row.is_last = (k + 1 == batch_len);
				row.has_res = 1'b0;
				row.res     = '0;
				drive_job(row, idle_pct);
				sent++;
			end
		end
		start <= 1'b0;

		// let the closing beat reach the checker, then drain
		@(posedge clk);
		while (sched_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
